[src/grid_broad_phase_collision_unit_defines.svh]
// ----------------------------------------------------------------------------
// grid broad phase collision unit - assertion macros
// shared concurrent assertion forms, clocked on clk and disabled in reset
// ----------------------------------------------------------------------------
`ifndef GRID_BROAD_PHASE_COLLISION_UNIT_DEFINES_SVH
`define GRID_BROAD_PHASE_COLLISION_UNIT_DEFINES_SVH

// condition holds at every edge
`define GBPC_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// consequent holds in the same cycle
`define GBPC_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// consequent holds in the next cycle
`define GBPC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

[src/gbpc_pkg.sv]
// ----------------------------------------------------------------------------
// gbpc_pkg
// types and constants of the grid broad phase collision unit
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package gbpc_pkg;

  localparam int MAX_BODIES_DEF = 64;
  localparam int COORD_BITS_DEF = 16;

  localparam int GRID_DIM    = 4;
  localparam int GRID_IDX_W  = 2;
  localparam int CELLS       = GRID_DIM * GRID_DIM;
  localparam int CELL_W      = 13;
  localparam int BODY_ID_W   = 6;
  localparam int BIN_STEPS   = 2 * (GRID_DIM + 1);
  localparam int STEP_W      = 4;
  localparam int EDGE_IDX_W  = 3;
  localparam int CFG_IDX_W   = 2;

  localparam logic [CELL_W-1:0] CELL_SIZE_RST = 13'd1024;

  localparam logic [CFG_IDX_W-1:0] CFG_WORLD_LEFT   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_WORLD_BOTTOM = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CELL_WIDTH   = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_CELL_HEIGHT  = 2'd3;

  typedef enum logic [1:0] {
    S_IDLE,
    S_BIN,
    S_SCAN,
    S_FINISH
  } gbpc_state_t;

  typedef struct packed {
    logic             done;
    logic [CELLS-1:0] mask;
  } gbpc_bin_stat_t;

endpackage

[src/gbpc_cell_binner.sv]
// ----------------------------------------------------------------------------
// gbpc_cell_binner
// walks the column and row edges with one adder and two comparators and
// builds the 4x4 cell mask of a box, one edge per cycle
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module gbpc_cell_binner #(
  parameter int COORD_BITS = gbpc_pkg::COORD_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  input  logic signed [COORD_BITS-1:0]      box_min_x,
  input  logic signed [COORD_BITS-1:0]      box_min_y,
  input  logic signed [COORD_BITS-1:0]      box_max_x,
  input  logic signed [COORD_BITS-1:0]      box_max_y,
  input  logic signed [COORD_BITS-1:0]      world_left,
  input  logic signed [COORD_BITS-1:0]      world_bottom,
  input  logic [gbpc_pkg::CELL_W-1:0]       cell_width,
  input  logic [gbpc_pkg::CELL_W-1:0]       cell_height,
  output gbpc_pkg::gbpc_bin_stat_t          stat
);

  localparam int EDGE_W = ((COORD_BITS > 16) ? COORD_BITS : 16) + 1;
  localparam int XW     = EDGE_W - COORD_BITS;
  localparam int WW     = EDGE_W - gbpc_pkg::CELL_W;

  logic                                  busy_r, busy_nxt;
  logic                                  done_r, done_nxt;
  logic [gbpc_pkg::STEP_W-1:0]           step_r, step_nxt;
  logic signed [EDGE_W-1:0]              edge_r, edge_nxt;
  logic [gbpc_pkg::GRID_DIM-1:0]         le_x_r, le_x_nxt, ge_x_r, ge_x_nxt;
  logic [gbpc_pkg::GRID_DIM-1:0]         le_y_r, le_y_nxt, ge_y_r, ge_y_nxt;

  logic                                  axis_y;
  logic [gbpc_pkg::EDGE_IDX_W-1:0]       k, km1;
  logic signed [EDGE_W-1:0]              b_lo, b_hi, wl_ext, wb_ext, sum;
  logic [gbpc_pkg::CELL_W-1:0]           w;
  logic                                  le, ge;
  logic [gbpc_pkg::CELLS-1:0]            mask;

  always_comb begin
    axis_y = step_r >= gbpc_pkg::STEP_W'(gbpc_pkg::GRID_DIM + 1);
    k      = axis_y ? gbpc_pkg::EDGE_IDX_W'(step_r - gbpc_pkg::STEP_W'(gbpc_pkg::GRID_DIM + 1))
                    : gbpc_pkg::EDGE_IDX_W'(step_r);
    km1    = k - gbpc_pkg::EDGE_IDX_W'(1);
    wl_ext = {{XW{world_left[COORD_BITS-1]}}, world_left};
    wb_ext = {{XW{world_bottom[COORD_BITS-1]}}, world_bottom};
    b_lo   = axis_y ? {{XW{box_min_y[COORD_BITS-1]}}, box_min_y}
                    : {{XW{box_min_x[COORD_BITS-1]}}, box_min_x};
    b_hi   = axis_y ? {{XW{box_max_y[COORD_BITS-1]}}, box_max_y}
                    : {{XW{box_max_x[COORD_BITS-1]}}, box_max_x};
    w      = axis_y ? cell_height : cell_width;
    // shared unit: one add, two compares
    sum    = edge_r + {{WW{1'b0}}, w};
    le     = edge_r <= b_hi;
    ge     = b_lo <= edge_r;
  end

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    step_nxt = step_r;
    edge_nxt = edge_r;
    le_x_nxt = le_x_r;
    ge_x_nxt = ge_x_r;
    le_y_nxt = le_y_r;
    ge_y_nxt = ge_y_r;
    if (start) begin
      busy_nxt = 1'b1;
      step_nxt = '0;
      edge_nxt = wl_ext;
    end else if (busy_r) begin
      if (k != gbpc_pkg::EDGE_IDX_W'(gbpc_pkg::GRID_DIM)) begin
        if (axis_y) le_y_nxt[k[gbpc_pkg::GRID_IDX_W-1:0]] = le;
        else        le_x_nxt[k[gbpc_pkg::GRID_IDX_W-1:0]] = le;
      end
      if (k != '0) begin
        if (axis_y) ge_y_nxt[km1[gbpc_pkg::GRID_IDX_W-1:0]] = ge;
        else        ge_x_nxt[km1[gbpc_pkg::GRID_IDX_W-1:0]] = ge;
      end
      // end of the column edges: restart at the bottom edge
      edge_nxt = (k == gbpc_pkg::EDGE_IDX_W'(gbpc_pkg::GRID_DIM)) ? wb_ext : sum;
      if (step_r == gbpc_pkg::STEP_W'(gbpc_pkg::BIN_STEPS - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end else begin
        step_nxt = step_r + gbpc_pkg::STEP_W'(1);
      end
    end
  end

  always_comb begin
    for (int r = 0; r < gbpc_pkg::GRID_DIM; r++) begin
      for (int c = 0; c < gbpc_pkg::GRID_DIM; c++) begin
        mask[r * gbpc_pkg::GRID_DIM + c] = le_y_r[r] & ge_y_r[r] & le_x_r[c] & ge_x_r[c];
      end
    end
  end

  assign stat.done = done_r;
  assign stat.mask = mask;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      step_r <= step_nxt;
    end
  end

  always_ff @(posedge clk) begin
    edge_r <= edge_nxt;
    le_x_r <= le_x_nxt;
    ge_x_r <= ge_x_nxt;
    le_y_r <= le_y_nxt;
    ge_y_r <= ge_y_nxt;
  end

endmodule

[src/gbpc_body_store.sv]
// ----------------------------------------------------------------------------
// gbpc_body_store
// body memory: box edges, cell mask and flags, one write and one
// registered read port
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module gbpc_body_store #(
  parameter int MAX_BODIES = gbpc_pkg::MAX_BODIES_DEF,
  parameter int COORD_BITS = gbpc_pkg::COORD_BITS_DEF
) (
  input  logic                                            clk,
  input  logic                                            wr_en,
  input  logic [((MAX_BODIES > 1) ? $clog2(MAX_BODIES) : 1)-1:0] wr_addr,
  input  logic [4*COORD_BITS+gbpc_pkg::CELLS+1:0]         wr_data,
  input  logic                                            rd_en,
  input  logic [((MAX_BODIES > 1) ? $clog2(MAX_BODIES) : 1)-1:0] rd_addr,
  output logic [4*COORD_BITS+gbpc_pkg::CELLS+1:0]         rd_data
);

  localparam int ENTRY_W = 4 * COORD_BITS + gbpc_pkg::CELLS + 2;

  logic [ENTRY_W-1:0] mem [MAX_BODIES];
  logic [ENTRY_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

[src/gbpc_pair_check.sv]
// ----------------------------------------------------------------------------
// gbpc_pair_check
// tests the new body against one stored body: shared cell, closed box
// overlap, both collidable and at least one moving
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module gbpc_pair_check #(
  parameter int COORD_BITS = gbpc_pkg::COORD_BITS_DEF
) (
  input  logic [4*COORD_BITS+gbpc_pkg::CELLS+1:0] entry,
  input  logic signed [COORD_BITS-1:0]            box_min_x,
  input  logic signed [COORD_BITS-1:0]            box_min_y,
  input  logic signed [COORD_BITS-1:0]            box_max_x,
  input  logic signed [COORD_BITS-1:0]            box_max_y,
  input  logic [gbpc_pkg::CELLS-1:0]              mask,
  input  logic [1:0]                              flags,
  output logic                                    hit
);

  localparam int ENTRY_W = 4 * COORD_BITS + gbpc_pkg::CELLS + 2;

  logic signed [COORD_BITS-1:0]  e_x0, e_y0, e_x1, e_y1;
  logic [gbpc_pkg::CELLS-1:0]    e_mask;
  logic [1:0]                    e_flags;
  logic                          share, ovl_x, ovl_y, coll, moving;

  always_comb begin
    e_x0    = entry[COORD_BITS-1:0];
    e_y0    = entry[2*COORD_BITS-1:COORD_BITS];
    e_x1    = entry[3*COORD_BITS-1:2*COORD_BITS];
    e_y1    = entry[4*COORD_BITS-1:3*COORD_BITS];
    e_mask  = entry[4*COORD_BITS+gbpc_pkg::CELLS-1:4*COORD_BITS];
    e_flags = entry[ENTRY_W-1 -: 2];
    share   = |(e_mask & mask);
    ovl_x   = (e_x0 <= box_max_x) && (box_min_x <= e_x1);
    ovl_y   = (e_y0 <= box_max_y) && (box_min_y <= e_y1);
    coll    = e_flags[0] & flags[0];
    moving  = e_flags[1] | flags[1];
    hit     = share & ovl_x & ovl_y & coll & moving;
  end

endmodule

[src/grid_broad_phase_collision_unit.sv]
// ----------------------------------------------------------------------------
// grid_broad_phase_collision_unit
// flow: each accepted body is binned, written to the store, scanned against the bodies
//   already stored and closed with a last result; when the frame is full it is dropped
// throughput: one body at a time; in_stall is high from accept until the last result
//   is issued, and output stalls can hold both the scan and the finish
// reset: synchronous; clears control, body count and configuration, not the memory
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "grid_broad_phase_collision_unit_defines.svh"

module grid_broad_phase_collision_unit #(
  parameter int MAX_BODIES = gbpc_pkg::MAX_BODIES_DEF,
  parameter int COORD_BITS = gbpc_pkg::COORD_BITS_DEF
) (
  input  logic                                    clk,
  input  logic                                    rst_n,
  input  logic                                    in_valid,
  output logic                                    in_stall,
  input  logic                                    in_frame_start,
  input  logic signed [COORD_BITS-1:0]            in_box_min_x,
  input  logic signed [COORD_BITS-1:0]            in_box_min_y,
  input  logic signed [COORD_BITS-1:0]            in_box_max_x,
  input  logic signed [COORD_BITS-1:0]            in_box_max_y,
  input  logic                                    in_can_collide,
  input  logic                                    in_is_moving,
  output logic                                    out_valid,
  input  logic                                    out_stall,
  output logic [gbpc_pkg::BODY_ID_W-1:0]          out_earlier_body,
  output logic [gbpc_pkg::BODY_ID_W-1:0]          out_this_body,
  output logic                                    out_pair_valid,
  output logic                                    out_last_result,
  output logic                                    out_frame_full,
  input  logic                                    cfg_valid,
  output logic                                    cfg_ready,
  input  logic [gbpc_pkg::CFG_IDX_W-1:0]          cfg_index,
  input  logic [((COORD_BITS > gbpc_pkg::CELL_W) ? COORD_BITS : gbpc_pkg::CELL_W)-1:0] cfg_data
);

  localparam int IDX_W   = (MAX_BODIES > 1) ? $clog2(MAX_BODIES) : 1;
  localparam int CNT_W   = $clog2(MAX_BODIES + 1);
  localparam int ENTRY_W = 4 * COORD_BITS + gbpc_pkg::CELLS + 2;
  localparam int ID_W    = gbpc_pkg::BODY_ID_W;

  gbpc_pkg::gbpc_state_t               state_r, state_nxt;
  logic [CNT_W-1:0]                    count_r, count_nxt;
  logic [IDX_W-1:0]                    idx_r, idx_nxt;
  logic [IDX_W-1:0]                    rd_idx_r, rd_idx_nxt;
  logic [IDX_W-1:0]                    chk_idx_r, chk_idx_nxt;
  logic                                chk_vld_r, chk_vld_nxt;
  logic [IDX_W-1:0]                    pend_r, pend_nxt;
  logic                                pend_vld_r, pend_vld_nxt;
  logic                                full_r, full_nxt;

  logic signed [COORD_BITS-1:0]        bx0_r, bx0_nxt, by0_r, by0_nxt;
  logic signed [COORD_BITS-1:0]        bx1_r, bx1_nxt, by1_r, by1_nxt;
  logic [1:0]                          flags_r, flags_nxt;
  logic [gbpc_pkg::CELLS-1:0]          mask_r, mask_nxt;

  logic                                out_valid_r, out_valid_nxt;
  logic [ID_W-1:0]                     out_earlier_r, out_earlier_nxt;
  logic [ID_W-1:0]                     out_this_r, out_this_nxt;
  logic                                out_pair_r, out_pair_nxt;
  logic                                out_last_r, out_last_nxt;
  logic                                out_full_r, out_full_nxt;

  logic signed [COORD_BITS-1:0]        world_left_r, world_bottom_r;
  logic [gbpc_pkg::CELL_W-1:0]         cell_width_r, cell_height_r;

  logic                                bin_start;
  gbpc_pkg::gbpc_bin_stat_t            bin_stat;
  logic                                wr_en, rd_en;
  logic [ENTRY_W-1:0]                  wr_data, rd_data;
  logic [gbpc_pkg::CELLS-1:0]          new_mask;
  logic                                hit, out_free, blocked;
  logic [CNT_W-1:0]                    eff_cnt;

  // config word port
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      world_left_r   <= '0;
      world_bottom_r <= '0;
      cell_width_r   <= gbpc_pkg::CELL_SIZE_RST;
      cell_height_r  <= gbpc_pkg::CELL_SIZE_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        gbpc_pkg::CFG_WORLD_LEFT:   world_left_r   <= cfg_data[COORD_BITS-1:0];
        gbpc_pkg::CFG_WORLD_BOTTOM: world_bottom_r <= cfg_data[COORD_BITS-1:0];
        gbpc_pkg::CFG_CELL_WIDTH:   cell_width_r   <= cfg_data[gbpc_pkg::CELL_W-1:0];
        gbpc_pkg::CFG_CELL_HEIGHT:  cell_height_r  <= cfg_data[gbpc_pkg::CELL_W-1:0];
        default: ;
      endcase
    end
  end

  gbpc_cell_binner #(
    .COORD_BITS (COORD_BITS)
  ) u_binner (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (bin_start),
    .box_min_x    (bx0_r),
    .box_min_y    (by0_r),
    .box_max_x    (bx1_r),
    .box_max_y    (by1_r),
    .world_left   (world_left_r),
    .world_bottom (world_bottom_r),
    .cell_width   (cell_width_r),
    .cell_height  (cell_height_r),
    .stat         (bin_stat)
  );

  assign new_mask = flags_r[0] ? bin_stat.mask : '0;
  assign wr_data  = {flags_r, new_mask, by1_r, bx1_r, by0_r, bx0_r};

  gbpc_body_store #(
    .MAX_BODIES (MAX_BODIES),
    .COORD_BITS (COORD_BITS)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (idx_r),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_idx_r),
    .rd_data (rd_data)
  );

  gbpc_pair_check #(
    .COORD_BITS (COORD_BITS)
  ) u_check (
    .entry     (rd_data),
    .box_min_x (bx0_r),
    .box_min_y (by0_r),
    .box_max_x (bx1_r),
    .box_max_y (by1_r),
    .mask      (mask_r),
    .flags     (flags_r),
    .hit       (hit)
  );

  assign in_stall = (state_r != gbpc_pkg::S_IDLE);
  assign out_free = !out_valid_r || !out_stall;
  assign eff_cnt  = in_frame_start ? '0 : count_r;
  assign blocked  = chk_vld_r && hit && pend_vld_r && !out_free;

  always_comb begin
    state_nxt       = state_r;
    count_nxt       = count_r;
    idx_nxt         = idx_r;
    rd_idx_nxt      = rd_idx_r;
    chk_idx_nxt     = chk_idx_r;
    chk_vld_nxt     = chk_vld_r;
    pend_nxt        = pend_r;
    pend_vld_nxt    = pend_vld_r;
    full_nxt        = full_r;
    bx0_nxt         = bx0_r;
    by0_nxt         = by0_r;
    bx1_nxt         = bx1_r;
    by1_nxt         = by1_r;
    flags_nxt       = flags_r;
    mask_nxt        = mask_r;
    out_valid_nxt   = out_valid_r && out_stall;
    out_earlier_nxt = out_earlier_r;
    out_this_nxt    = out_this_r;
    out_pair_nxt    = out_pair_r;
    out_last_nxt    = out_last_r;
    out_full_nxt    = out_full_r;
    bin_start       = 1'b0;
    wr_en           = 1'b0;
    rd_en           = 1'b0;
    case (state_r)
      gbpc_pkg::S_IDLE: begin
        if (in_valid) begin
          bx0_nxt   = in_box_min_x;
          by0_nxt   = in_box_min_y;
          bx1_nxt   = in_box_max_x;
          by1_nxt   = in_box_max_y;
          flags_nxt = {in_is_moving, in_can_collide};
          if (eff_cnt == CNT_W'(MAX_BODIES)) begin
            full_nxt  = 1'b1;
            state_nxt = gbpc_pkg::S_FINISH;
          end else begin
            full_nxt  = 1'b0;
            idx_nxt   = eff_cnt[IDX_W-1:0];
            count_nxt = eff_cnt + CNT_W'(1);
            bin_start = 1'b1;
            state_nxt = gbpc_pkg::S_BIN;
          end
        end
      end
      gbpc_pkg::S_BIN: begin
        if (bin_stat.done) begin
          wr_en        = 1'b1;
          mask_nxt     = new_mask;
          rd_idx_nxt   = '0;
          chk_vld_nxt  = 1'b0;
          pend_vld_nxt = 1'b0;
          state_nxt    = gbpc_pkg::S_SCAN;
        end
      end
      gbpc_pkg::S_SCAN: begin
        if (!blocked) begin
          if (chk_vld_r && hit) begin
            // a newer pair shows the held one is not the last
            if (pend_vld_r) begin
              out_valid_nxt   = 1'b1;
              out_earlier_nxt = ID_W'(pend_r);
              out_this_nxt    = ID_W'(idx_r);
              out_pair_nxt    = 1'b1;
              out_last_nxt    = 1'b0;
              out_full_nxt    = 1'b0;
            end
            pend_nxt     = chk_idx_r;
            pend_vld_nxt = 1'b1;
          end
          if (rd_idx_r != idx_r) begin
            rd_en       = 1'b1;
            chk_vld_nxt = 1'b1;
            chk_idx_nxt = rd_idx_r;
            rd_idx_nxt  = rd_idx_r + IDX_W'(1);
          end else begin
            chk_vld_nxt = 1'b0;
            if (!chk_vld_r) begin
              state_nxt = gbpc_pkg::S_FINISH;
            end
          end
        end
      end
      gbpc_pkg::S_FINISH: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_last_nxt  = 1'b1;
          out_full_nxt  = full_r;
          if (full_r) begin
            out_earlier_nxt = '0;
            out_this_nxt    = '0;
            out_pair_nxt    = 1'b0;
          end else if (pend_vld_r) begin
            out_earlier_nxt = ID_W'(pend_r);
            out_this_nxt    = ID_W'(idx_r);
            out_pair_nxt    = 1'b1;
          end else begin
            out_earlier_nxt = '0;
            out_this_nxt    = ID_W'(idx_r);
            out_pair_nxt    = 1'b0;
          end
          pend_vld_nxt = 1'b0;
          state_nxt    = gbpc_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = gbpc_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= gbpc_pkg::S_IDLE;
      count_r     <= '0;
      chk_vld_r   <= 1'b0;
      pend_vld_r  <= 1'b0;
      full_r      <= 1'b0;
      out_valid_r <= 1'b0;
      rd_idx_r    <= '0;
      idx_r       <= '0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      chk_vld_r   <= chk_vld_nxt;
      pend_vld_r  <= pend_vld_nxt;
      full_r      <= full_nxt;
      out_valid_r <= out_valid_nxt;
      rd_idx_r    <= rd_idx_nxt;
      idx_r       <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    chk_idx_r     <= chk_idx_nxt;
    pend_r        <= pend_nxt;
    bx0_r         <= bx0_nxt;
    by0_r         <= by0_nxt;
    bx1_r         <= bx1_nxt;
    by1_r         <= by1_nxt;
    flags_r       <= flags_nxt;
    mask_r        <= mask_nxt;
    out_earlier_r <= out_earlier_nxt;
    out_this_r    <= out_this_nxt;
    out_pair_r    <= out_pair_nxt;
    out_last_r    <= out_last_nxt;
    out_full_r    <= out_full_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_earlier_body = out_earlier_r;
  assign out_this_body    = out_this_r;
  assign out_pair_valid   = out_pair_r;
  assign out_last_result  = out_last_r;
  assign out_frame_full   = out_full_r;

  `GBPC_ASSERT_ALWAYS(a_count_range, count_r <= CNT_W'(MAX_BODIES),
                      "body count beyond capacity")
  `GBPC_ASSERT_IMP(a_scan_bound, state_r == gbpc_pkg::S_SCAN, rd_idx_r <= idx_r,
                   "scan ran past body")
  `GBPC_ASSERT_IMP(a_pend_state, pend_vld_r,
                   state_r == gbpc_pkg::S_SCAN || state_r == gbpc_pkg::S_FINISH,
                   "held pair outside scan")
  `GBPC_ASSERT_IMP(a_pair_order, out_valid_r && out_pair_r, out_earlier_r < out_this_r,
                   "pair not lower index first")
  `GBPC_ASSERT_NEXT(a_accept_busy, in_valid && !in_stall, state_r != gbpc_pkg::S_IDLE,
                    "word taken but unit idle")

endmodule
